### rtl/stsmc_pkg.sv
`default_nettype none

package stsmc_pkg;

  // Fixed number formats.
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int GAIN_W    = 31;

  // Error divider: |reference - measured| needs 33 bits, padded to whole digits.
  localparam int DIVISOR    = 100;
  localparam int DIGIT_W    = 4;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int DIV_W      = ((DIFF_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int DIV_DIGITS = DIV_W / DIGIT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_DIGITS);
  localparam int REM_W      = 7;
  localparam int QMAG_W     = 26;

  // Square root of the error magnitude in Q16.16.
  localparam int ROOT_W     = (QMAG_W + FRAC_BITS + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ZONE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]        KP_GAIN_RST        = 31'd2621440;
  localparam logic [GAIN_W-1:0]        KI_GAIN_RST        = 31'd65536;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST        = 32'sd1572864;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST        = -32'sd1572864;
  localparam logic [GAIN_W-1:0]        ERROR_ZONE_RST     = 31'd65536;
  localparam logic [GAIN_W-1:0]        INTEGRAL_LIMIT_RST = 31'd1572864;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Classified error handed from the front to the back.
  typedef struct packed {
    logic              neg;
    logic [QMAG_W-1:0] mag;
    logic              in_zone;
  } err_item_t;

  // Settings used by the back.
  typedef struct packed {
    logic [GAIN_W-1:0]        kp_gain;
    logic [GAIN_W-1:0]        ki_gain;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
    logic [GAIN_W-1:0]        integral_limit;
  } back_cfg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SQRT,
    B_MUL_P,
    B_SUM
  } back_state_t;

endpackage

`default_nettype wire

### rtl/super_twisting_smc_controller.sv
// The back handles one transaction at a time, paced by the 21-step square root and held while an unread result waits.
// The front divides the error in 9 digit steps and takes a new transaction while the back works.
// Reset (rst, synchronous) clears the integral and the queue, marks the result empty, and restores default settings.
`default_nettype none

module super_twisting_smc_controller
  import stsmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [DATA_W-1:0] reference,
  input  wire logic signed [DATA_W-1:0] measured,
  output logic                          empty,
  input  wire logic                     pop,
  output logic signed [DATA_W-1:0]      drive,
  output logic                          output_clamped,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  logic [GAIN_W-1:0]        kp_gain;
  logic [GAIN_W-1:0]        ki_gain;
  logic signed [DATA_W-1:0] out_max;
  logic signed [DATA_W-1:0] out_min;
  logic [GAIN_W-1:0]        error_zone;
  logic [GAIN_W-1:0]        integral_limit;

  back_cfg_t back_cfg;
  err_item_t fq_item_in;
  err_item_t fq_item_out;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= KP_GAIN_RST;
      ki_gain        <= KI_GAIN_RST;
      out_max        <= OUT_MAX_RST;
      out_min        <= OUT_MIN_RST;
      error_zone     <= ERROR_ZONE_RST;
      integral_limit <= INTEGRAL_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KP_GAIN:        kp_gain        <= cfg_data[GAIN_W-1:0];
        CFG_KI_GAIN:        ki_gain        <= cfg_data[GAIN_W-1:0];
        CFG_OUT_MAX:        out_max        <= $signed(cfg_data);
        CFG_OUT_MIN:        out_min        <= $signed(cfg_data);
        CFG_ERROR_ZONE:     error_zone     <= cfg_data[GAIN_W-1:0];
        CFG_INTEGRAL_LIMIT: integral_limit <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    back_cfg.kp_gain        = kp_gain;
    back_cfg.ki_gain        = ki_gain;
    back_cfg.out_max        = out_max;
    back_cfg.out_min        = out_min;
    back_cfg.integral_limit = integral_limit;
  end

  // Front: takes samples, divides the error and checks the zone.
  stsmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .reference  (reference),
    .measured   (measured),
    .error_zone (error_zone),
    .q_push     (q_push),
    .q_item     (fq_item_in),
    .q_full     (q_full)
  );

  // Short queue between the two halves.
  stsmc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (fq_item_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (fq_item_out),
    .empty    (q_empty)
  );

  // Back: square root, integral and clamped output.
  stsmc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (back_cfg),
    .q_empty        (q_empty),
    .q_item         (fq_item_out),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .drive          (drive),
    .output_clamped (output_clamped)
  );

`ifndef SYNTHESIS
  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("front pushed into a full queue");

  // The back never takes from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  // An accepted transaction makes the front busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (push && !full) |=> full)
    else $error("front did not go busy after accepting a transaction");
`endif

endmodule

`default_nettype wire

### rtl/stsmc_front.sv
`default_nettype none

module stsmc_front
  import stsmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [DATA_W-1:0] reference,
  input  wire logic signed [DATA_W-1:0] measured,
  input  wire logic [GAIN_W-1:0]        error_zone,
  output logic                          q_push,
  output err_item_t                     q_item,
  input  wire logic                     q_full
);

  front_state_t state, state_next;

  logic [DIV_W-1:0]     dividend;
  logic [REM_W-1:0]     rem;
  logic [QMAG_W-1:0]    quot;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic [REM_W:0]           rem_step;
  logic [DIGIT_W-1:0]       qdigit;
  logic                     accept;

  assign accept = push && !full;

  // Difference of the two samples and its magnitude.
  always_comb begin
    diff     = DIFF_W'(reference) - DIFF_W'(measured);
    diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // One quotient digit of the division by the constant: a few narrow compare-subtracts.
  always_comb begin
    rem_step = {1'b0, rem};
    qdigit   = '0;
    for (int k = 0; k < DIGIT_W; k++) begin
      rem_step = {rem_step[REM_W-1:0], dividend[DIV_W-1-k]};
      if (rem_step >= (REM_W+1)'(DIVISOR)) begin
        rem_step            = rem_step - (REM_W+1)'(DIVISOR);
        qdigit[DIGIT_W-1-k] = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_DIV;
      end
      F_DIV: begin
        if (cnt == '0) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    unique case (state)
      F_IDLE:  full = 1'b0;
      F_DIV:   full = 1'b1;
      F_PUSH:  q_push = !q_full;
      default: full = 1'b1;
    endcase
  end

  // The item handed on: sign, magnitude and whether it lies inside the error zone.
  always_comb begin
    q_item.neg     = neg;
    q_item.mag     = quot;
    q_item.in_zone = GAIN_W'(quot) < error_zone;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Division datapath, one digit per cycle.
  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      dividend <= DIV_W'(diff_mag);
      rem      <= '0;
      quot     <= '0;
      neg      <= diff[DIFF_W-1];
      cnt      <= DIV_CNT_W'(DIV_DIGITS - 1);
    end else if (state == F_DIV) begin
      dividend <= dividend << DIGIT_W;
      rem      <= rem_step[REM_W-1:0];
      quot     <= {quot[QMAG_W-DIGIT_W-1:0], qdigit};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/stsmc_fifo.sv
`default_nettype none

module stsmc_fifo
  import stsmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire err_item_t item_in,
  output logic           full,
  input  wire logic      pop,
  output err_item_t      item_out,
  output logic           empty
);

  err_item_t entries [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= item_in;
  end

endmodule

`default_nettype wire

### rtl/stsmc_back.sv
`default_nettype none

module stsmc_back
  import stsmc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire back_cfg_t                cfg,
  input  wire logic                     q_empty,
  input  wire err_item_t                q_item,
  output logic                          q_pop,
  output logic                          empty,
  input  wire logic                     pop,
  output logic signed [DATA_W-1:0]      drive,
  output logic                          output_clamped
);

  localparam int PROD_W  = 2 * DATA_W;
  localparam int STEP_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W   = STEP_W + 1;
  localparam int PMAG_W  = GAIN_W + ROOT_W - FRAC_BITS;
  localparam int SUM_W   = PMAG_W + 2;

  back_state_t state, state_next;

  // Current item.
  logic              neg;
  logic [QMAG_W-1:0] mag;
  logic              in_zone;

  // Square root unit.
  logic [RAD_W-1:0]      rad;
  logic [RAD_W-1:0]      root;
  logic [RAD_W-1:0]      bitm;
  logic [SQRT_CNT_W-1:0] cnt;

  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] integral_sum;
  logic                     res_valid;

  logic [RAD_W-1:0]         trial;
  logic                     take;
  logic signed [DATA_W-1:0] err_s;
  logic [GAIN_W-1:0]        mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  lim_pos;
  logic signed [ACC_W-1:0]  lim_neg;
  logic signed [DATA_W-1:0] integral_next;
  logic signed [SUM_W-1:0]  prop;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_hi;
  logic signed [SUM_W-1:0]  sum_lo;
  logic signed [SUM_W-1:0]  omax;
  logic signed [SUM_W-1:0]  omin;
  logic                     clamp_hi;
  logic                     clamp_lo;
  logic                     res_write;

  // Signed error rebuilt from sign and magnitude.
  always_comb begin
    err_s = neg ? -$signed(DATA_W'(mag)) : $signed(DATA_W'(mag));
  end

  // One step of the bitwise square root.
  always_comb begin
    trial = root + bitm;
    take  = rad >= trial;
  end

  // Shared multiplier operands: integral gain times error, or sliding gain times root.
  always_comb begin
    if (state == B_MUL_P) begin
      mul_a = cfg.kp_gain;
      mul_b = $signed(DATA_W'(root[ROOT_W-1:0]));
    end else begin
      mul_a = cfg.ki_gain;
      mul_b = err_s;
    end
  end

  // Integral update with its symmetric clamp; the step is floored by the shift.
  always_comb begin
    acc     = ACC_W'(integral_sum) + ACC_W'($signed(prod[PROD_W-1:FRAC_BITS]));
    lim_pos = $signed(ACC_W'(cfg.integral_limit));
    lim_neg = -lim_pos;
    if (acc > lim_pos) begin
      integral_next = lim_pos[DATA_W-1:0];
    end else if (acc < lim_neg) begin
      integral_next = lim_neg[DATA_W-1:0];
    end else begin
      integral_next = acc[DATA_W-1:0];
    end
  end

  // Output sum: lowered to the upper limit first, then raised to the lower one.
  always_comb begin
    prop     = $signed(SUM_W'(prod[FRAC_BITS+PMAG_W-1:FRAC_BITS]));
    if (neg) prop = -prop;
    sum      = prop + SUM_W'(integral_sum);
    omax     = SUM_W'(cfg.out_max);
    omin     = SUM_W'(cfg.out_min);
    clamp_hi = sum > omax;
    sum_hi   = clamp_hi ? omax : sum;
    clamp_lo = sum_hi < omin;
    sum_lo   = clamp_lo ? omin : sum_hi;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) state_next = B_SQRT;
      end
      B_SQRT: begin
        if (cnt == '0) state_next = B_MUL_P;
      end
      B_MUL_P: state_next = B_SUM;
      B_SUM: begin
        if (!res_valid || pop) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    q_pop     = 1'b0;
    res_write = 1'b0;
    unique case (state)
      B_IDLE:  q_pop = !q_empty;
      B_SQRT:  q_pop = 1'b0;
      B_MUL_P: q_pop = 1'b0;
      B_SUM:   res_write = !res_valid || pop;
      default: q_pop = 1'b0;
    endcase
  end

  assign empty = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      integral_sum <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      // In zone, the integral moves during the root, after the product is ready.
      if (state == B_SQRT && cnt == SQRT_CNT_W'(SQRT_STEPS - 2) && in_zone) begin
        integral_sum <= integral_next;
      end
      if (res_write) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Item load, root iterations and the shared multiplier.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) begin
      neg     <= q_item.neg;
      mag     <= q_item.mag;
      in_zone <= q_item.in_zone;
      rad     <= {q_item.mag, {FRAC_BITS{1'b0}}};
      root    <= '0;
      bitm    <= RAD_W'(1) << (RAD_W - 2);
      cnt     <= SQRT_CNT_W'(SQRT_STEPS - 1);
    end else if (state == B_SQRT) begin
      if (take) begin
        rad  <= rad - trial;
        root <= (root >> 1) + bitm;
      end else begin
        root <= root >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt - 1'b1;
    end
    if ((state == B_SQRT && cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) || state == B_MUL_P) begin
      prod <= $signed({1'b0, mul_a}) * mul_b;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (res_write) begin
      drive          <= sum_lo[DATA_W-1:0];
      output_clamped <= clamp_hi || clamp_lo;
    end
  end

endmodule

`default_nettype wire
